FILE: sv/dmsc_pkg.sv
// Package for the differential motor speed control block.
// Holds command codes, selector codes, register indexes and the payload structs.
// No dependencies.
package dmsc_pkg;

  // Fixed field widths of the channels
  localparam int FIELD_W   = 8;
  localparam int CMD_W     = 3;
  localparam int SEL_W     = 2;
  localparam int CFG_IDX_W = 1;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_STOP       = 3'd0,
    CMD_START_FWD  = 3'd1,
    CMD_START_BACK = 3'd2,
    CMD_SET_SPEED  = 3'd3,
    CMD_STEP_UP    = 3'd4,
    CMD_STEP_DOWN  = 3'd5,
    CMD_ADJUST     = 3'd6,
    CMD_SET_DIR    = 3'd7
  } cmd_t;

  // Motor selector codes; both of the last two select both motors
  localparam logic [SEL_W-1:0] SEL_LEFT     = 2'd0;
  localparam logic [SEL_W-1:0] SEL_RIGHT    = 2'd1;
  localparam logic [SEL_W-1:0] SEL_BOTH     = 2'd2;
  localparam logic [SEL_W-1:0] SEL_BOTH_ALT = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX     = 1'd1;

  // Register reset values
  localparam logic [FIELD_W-1:0] NOMINAL_RESET = 8'd128;
  localparam logic [FIELD_W-1:0] MAX_RESET     = 8'd255;

  // Status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_LIMIT = 1'b1;

  typedef struct packed {
    cmd_t               cmd;
    logic [SEL_W-1:0]   motor_select;
    logic [FIELD_W-1:0] amount;
    logic               direction_forward;
  } item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] nominal_speed;
    logic [FIELD_W-1:0] max_speed;
  } cfg_regs_t;

  typedef struct packed {
    logic [FIELD_W-1:0] left_duty;
    logic [FIELD_W-1:0] right_duty;
    logic               left_forward;
    logic               right_forward;
    logic               status;
  } res_t;

endpackage

FILE: sv/dmsc_cmd_if.sv
// Command channel: valid/ready handshake carrying one motor command.
// Depends on dmsc_pkg for field widths.
interface dmsc_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [dmsc_pkg::CMD_W-1:0]   cmd;
  logic [dmsc_pkg::SEL_W-1:0]   motor_select;
  logic [dmsc_pkg::FIELD_W-1:0] amount;
  logic                         direction_forward;

  modport source (output valid, output cmd, output motor_select, output amount,
                  output direction_forward, input ready);
  modport sink (input valid, input cmd, input motor_select, input amount,
                input direction_forward, output ready);
endinterface

FILE: sv/dmsc_res_if.sv
// Result channel: valid/ready handshake carrying both duties, directions and status.
// Depends on dmsc_pkg for field widths.
interface dmsc_res_if;
  logic                         valid;
  logic                         ready;
  logic [dmsc_pkg::FIELD_W-1:0] left_duty;
  logic [dmsc_pkg::FIELD_W-1:0] right_duty;
  logic                         left_forward;
  logic                         right_forward;
  logic                         status;

  modport source (output valid, output left_duty, output right_duty, output left_forward,
                  output right_forward, output status, input ready);
  modport sink (input valid, input left_duty, input right_duty, input left_forward,
                input right_forward, input status, output ready);
endinterface

FILE: sv/dmsc_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on dmsc_pkg for field widths.
interface dmsc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dmsc_pkg::CFG_IDX_W-1:0] index;
  logic [dmsc_pkg::FIELD_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/dmsc_cfg_regs.sv
// Configuration registers: nominal speed and maximum speed.
// Depends on dmsc_pkg and dmsc_cfg_if.
module dmsc_cfg_regs (
  input  logic                 clk,
  input  logic                 rst,
  dmsc_cfg_if.sink             cfg,
  output dmsc_pkg::cfg_regs_t  regs
);
  import dmsc_pkg::*;

  cfg_regs_t cfg_q;

  // Accept every write at once
  assign cfg.ready = 1'b1;

  // Update the addressed register on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.nominal_speed <= NOMINAL_RESET;
      cfg_q.max_speed     <= MAX_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_NOMINAL: cfg_q.nominal_speed <= cfg.data;
        REG_MAX:     cfg_q.max_speed     <= cfg.data;
      endcase
    end
  end

  assign regs = cfg_q;

endmodule

FILE: sv/dmsc_step.sv
// Next-state logic for one command: stop, start, set speed, step, adjust, set direction.
// Depends on dmsc_pkg.
module dmsc_step #(
  parameter int DUTY_BITS = 8
) (
  input  dmsc_pkg::item_t        item,
  input  dmsc_pkg::cfg_regs_t    regs,
  input  logic [DUTY_BITS-1:0]   left_speed,
  input  logic [DUTY_BITS-1:0]   right_speed,
  input  logic                   left_dir,
  input  logic                   right_dir,
  output logic [DUTY_BITS-1:0]   left_speed_next,
  output logic [DUTY_BITS-1:0]   right_speed_next,
  output logic                   left_dir_next,
  output logic                   right_dir_next,
  output logic                   status
);
  import dmsc_pkg::*;

  // Compare width and signed width for the adjust arithmetic
  localparam int CW = (DUTY_BITS > FIELD_W) ? DUTY_BITS : FIELD_W;
  localparam int SW = CW + 3;

  // Step one duty by one; MSB of the result flags the limit
  function automatic logic [DUTY_BITS:0] step_one(input logic [DUTY_BITS-1:0] spd,
                                                  input logic up,
                                                  input logic [FIELD_W-1:0] max_spd);
    logic [DUTY_BITS:0] res;
    res = {STATUS_LIMIT, spd};
    if (up) begin
      if (CW'(spd) < CW'(max_spd)) res = {STATUS_OK, spd + 1'b1};
    end else begin
      if (spd != '0) res = {STATUS_OK, spd - 1'b1};
    end
    return res;
  endfunction

  logic [DUTY_BITS-1:0] start_duty;
  logic [DUTY_BITS-1:0] set_duty;
  logic                 step_up;
  logic [DUTY_BITS:0]   step_l;
  logic [DUTY_BITS:0]   step_r;
  logic [DUTY_BITS:0]   step_l2;
  logic                 sel_left;
  logic                 sel_right;
  logic signed [SW-1:0] n, m, p, l0, r0;
  logic signed [SW-1:0] own, oth, own_n, oth_n;
  logic signed [SW-1:0] l1, r1, l2, r2, l3, r3, l4, r4;
  logic [DUTY_BITS-1:0] adj_left;
  logic [DUTY_BITS-1:0] adj_right;

  assign sel_left  = (item.motor_select == SEL_LEFT);
  assign sel_right = (item.motor_select == SEL_RIGHT);

  // Limit start and set-speed duties to the maximum
  assign start_duty = (regs.nominal_speed > regs.max_speed) ? DUTY_BITS'(regs.max_speed)
                                                            : DUTY_BITS'(regs.nominal_speed);
  assign set_duty   = (item.amount > regs.max_speed) ? DUTY_BITS'(regs.max_speed)
                                                     : DUTY_BITS'(item.amount);

  // Single steps on each side; left after a right step when both are selected
  assign step_up = (item.cmd == CMD_STEP_UP);
  assign step_l  = step_one(left_speed, step_up, regs.max_speed);
  assign step_r  = step_one(right_speed, step_up, regs.max_speed);
  assign step_l2 = step_l;

  // Differential adjust around the nominal duty, then clamp to 0..max
  always_comb begin
    n  = SW'(regs.nominal_speed);
    m  = SW'(regs.max_speed);
    p  = SW'(item.amount);
    l0 = SW'(left_speed);
    r0 = SW'(right_speed);
    own = sel_left ? l0 : r0;
    oth = sel_left ? r0 : l0;
    if (own - p > n) begin
      own_n = own - p;
      oth_n = oth;
    end else if (own > n) begin
      own_n = n;
      oth_n = oth + p - n;
    end else begin
      own_n = own;
      oth_n = oth + p;
    end
    l1 = sel_left ? own_n : oth_n;
    r1 = sel_left ? oth_n : own_n;
    // Excess on the right comes off the left
    if (r1 > m) begin
      l2 = l1 - (r1 - m);
      r2 = m;
    end else begin
      l2 = l1;
      r2 = r1;
    end
    l3 = (l2 < 0) ? '0 : l2;
    // Excess on the left comes off the right
    if (l3 > m) begin
      r3 = r2 - (l3 - m);
      l4 = m;
    end else begin
      r3 = r2;
      l4 = l3;
    end
    r4 = (r3 < 0) ? '0 : r3;
    adj_left  = DUTY_BITS'(l4);
    adj_right = DUTY_BITS'(r4);
  end

  // Select the next state by command
  always_comb begin
    left_speed_next  = left_speed;
    right_speed_next = right_speed;
    left_dir_next    = left_dir;
    right_dir_next   = right_dir;
    status           = STATUS_OK;
    unique case (item.cmd)
      CMD_STOP: begin
        left_speed_next  = '0;
        right_speed_next = '0;
      end
      CMD_START_FWD, CMD_START_BACK: begin
        left_dir_next    = (item.cmd == CMD_START_FWD);
        right_dir_next   = (item.cmd == CMD_START_FWD);
        left_speed_next  = start_duty;
        right_speed_next = start_duty;
      end
      CMD_SET_SPEED: begin
        left_speed_next  = set_duty;
        right_speed_next = set_duty;
      end
      CMD_STEP_UP, CMD_STEP_DOWN: begin
        priority if (sel_left) begin
          left_speed_next = step_l[DUTY_BITS-1:0];
          status          = step_l[DUTY_BITS];
        end else if (sel_right) begin
          right_speed_next = step_r[DUTY_BITS-1:0];
          status           = step_r[DUTY_BITS];
        end else if (step_r[DUTY_BITS] == STATUS_LIMIT) begin
          status = STATUS_LIMIT;
        end else begin
          // Keep the right step even when the left one hits the limit
          right_speed_next = step_r[DUTY_BITS-1:0];
          left_speed_next  = step_l2[DUTY_BITS-1:0];
          status           = step_l2[DUTY_BITS];
        end
      end
      CMD_ADJUST: begin
        left_speed_next  = adj_left;
        right_speed_next = adj_right;
      end
      CMD_SET_DIR: begin
        if (!sel_right) left_dir_next  = item.direction_forward;
        if (!sel_left)  right_dir_next = item.direction_forward;
      end
    endcase
  end

endmodule

FILE: sv/differential_motor_speed_control.sv
// Top level of the differential motor speed control block.
// Depends on dmsc_pkg, the channel interfaces, dmsc_cfg_regs and dmsc_step.
//
//   Channel   Dir   Handshake      Payload
//   command   in    valid/ready    cmd, motor_select, amount, direction_forward
//   result    out   valid/ready    left_duty, right_duty, left_forward, right_forward, status
//   cfg       in    valid/ready    index, data (0 nominal_speed, 1 max_speed)
//
// One command per cycle sustained while results are taken; a command passes through the input
// register, then the result register, with the state updated as the result is loaded.
// Reset clears both duties and directions, loads nominal 128 and maximum 255, empties both stages.
// While the result waits, the input register still takes one command; command.ready drops
// only when both stages are full and the result is not taken. Configuration is never stalled.
module differential_motor_speed_control #(
  parameter int DUTY_BITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  dmsc_cmd_if.sink  command,
  dmsc_res_if.source result,
  dmsc_cfg_if.sink  cfg
);
  import dmsc_pkg::*;

  cfg_regs_t            regs;
  logic                 s1_valid;
  item_t                s1_item;
  logic                 res_valid;
  res_t                 res_data;
  logic                 out_free;
  logic                 s1_fire;
  logic [DUTY_BITS-1:0] left_speed;
  logic [DUTY_BITS-1:0] right_speed;
  logic                 left_dir;
  logic                 right_dir;
  logic [DUTY_BITS-1:0] left_speed_next;
  logic [DUTY_BITS-1:0] right_speed_next;
  logic                 left_dir_next;
  logic                 right_dir_next;
  logic                 status_next;

  dmsc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  dmsc_step #(.DUTY_BITS(DUTY_BITS)) u_step (
    .item             (s1_item),
    .regs             (regs),
    .left_speed       (left_speed),
    .right_speed      (right_speed),
    .left_dir         (left_dir),
    .right_dir        (right_dir),
    .left_speed_next  (left_speed_next),
    .right_speed_next (right_speed_next),
    .left_dir_next    (left_dir_next),
    .right_dir_next   (right_dir_next),
    .status           (status_next)
  );

  // Handshake control
  assign out_free      = !res_valid || result.ready;
  assign s1_fire       = s1_valid && out_free;
  assign command.ready = !s1_valid || out_free;

  // Input register: take a command, release it once its result is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (command.valid && command.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_item <= '0;
    end else if (command.valid && command.ready) begin
      s1_item.cmd               <= cmd_t'(command.cmd);
      s1_item.motor_select      <= command.motor_select;
      s1_item.amount            <= command.amount;
      s1_item.direction_forward <= command.direction_forward;
    end
  end

  // Motor state: advance on each command that moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      left_speed  <= '0;
      right_speed <= '0;
      left_dir    <= 1'b0;
      right_dir   <= 1'b0;
    end else if (s1_fire) begin
      left_speed  <= left_speed_next;
      right_speed <= right_speed_next;
      left_dir    <= left_dir_next;
      right_dir   <= right_dir_next;
    end
  end

  // Result register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_data.left_duty     <= FIELD_W'(left_speed_next);
      res_data.right_duty    <= FIELD_W'(right_speed_next);
      res_data.left_forward  <= left_dir_next;
      res_data.right_forward <= right_dir_next;
      res_data.status        <= status_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.left_duty     = res_data.left_duty;
  assign result.right_duty    = res_data.right_duty;
  assign result.left_forward  = res_data.left_forward;
  assign result.right_forward = res_data.right_forward;
  assign result.status        = res_data.status;

  // A loaded command always produces a result next cycle
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> result.valid)
    else $error("result not presented after command was loaded");

  // A transferred command sits in the input register next cycle
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    command.valid && command.ready |=> s1_valid)
    else $error("accepted command lost");

  // Motor state changes only when a command is loaded
  a_state_stable: assert property (@(posedge clk) disable iff (rst)
    !s1_fire |=> $stable(left_speed) && $stable(right_speed)
                 && $stable(left_dir) && $stable(right_dir))
    else $error("motor state changed without a command");

  // Only step commands may report a limit
  a_status_steps_only: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !(s1_item.cmd == CMD_STEP_UP || s1_item.cmd == CMD_STEP_DOWN)
    |=> result.status == STATUS_OK)
    else $error("limit status on a non-step command");

endmodule
